// ===== rtl/sle_pkg.sv =====
package sle_pkg;

   localparam logic [1:0] MODE_LOOKAHEAD = 2'd0;
   localparam logic [1:0] MODE_FULL      = 2'd1;
   localparam logic [1:0] MODE_MARKUP    = 2'd2;

   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_QUOTE  = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_AMP    = 8'h26;
   localparam logic [7:0] CHAR_LT     = 8'h3c;
   localparam logic [7:0] CHAR_EQ     = 8'h3d;
   localparam logic [7:0] CHAR_GT     = 8'h3e;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_2      = 8'h32;
   localparam logic [7:0] CHAR_3      = 8'h33;
   localparam logic [7:0] CHAR_5      = 8'h35;
   localparam logic [7:0] CHAR_7      = 8'h37;
   localparam logic [7:0] CHAR_C      = 8'h63;
   localparam logic [7:0] CHAR_D      = 8'h64;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_6      = 8'h36;

   // bytes that let a held backslash stay single: backslash, n, r, t
   localparam logic [24:0] LOOKAHEAD_MASK = 25'h1440001;
   localparam logic [7:0]  LOOKAHEAD_SPAN = 8'h18;

   // prefix: resolution of a held backslash
   localparam logic [1:0] PRE_NONE   = 2'd0;
   localparam logic [1:0] PRE_SINGLE = 2'd1;
   localparam logic [1:0] PRE_HEX    = 2'd2;

   // body: what the item's own byte becomes
   localparam logic [1:0] BODY_NONE = 2'd0;
   localparam logic [1:0] BODY_RAW  = 2'd1;
   localparam logic [1:0] BODY_PAIR = 2'd2;
   localparam logic [1:0] BODY_HEX  = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } rsp_type;

   typedef struct packed {
      logic [1:0] pre;
      logic [1:0] body;
      logic [7:0] arg_a;
      logic [7:0] arg_b;
      logic       last;
   } job_type;

endpackage

// ===== rtl/string_literal_escaper_top.sv =====
// Channel   Direction  Handshake             Payload
// request   in         push / full          req_item  (in_byte, end_of_string)
// response  out        empty / pop          rsp_item  (out_byte, last_of_run, string_done)
// csr       in         csr_wr_en            csr_wr_data (escape_mode)
//
// A byte that passes unchanged gives one output beat; an item gives one beat per output
// byte (up to eight), serialized by the back end one byte per cycle while the output stage is free or popped.
// Items that produce no output (a held backslash) stop at the front end and never enter the queue.
// The first result passes through the job queue and then the output register to the response ports.
// Reset is synchronous; it empties the queue and output stage and clears the mode.
// full reflects only the job queue, so input keeps flowing while a result waits
// until the job queue fills.
module string_literal_escaper_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sle_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output sle_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);
   import sle_pkg::*;

   logic    accept;
   logic    job_push;
   job_type front_job;
   logic    q_valid;
   job_type q_job;
   logic    job_done;

   assign accept = push && !full;

   sle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .item        (req_item),
      .job_push    (job_push),
      .job         (front_job)
   );

   sle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_push),
      .wr_job   (front_job),
      .q_full   (full),
      .rd_en    (job_done),
      .rd_valid (q_valid),
      .rd_job   (q_job)
   );

   sle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .job_done  (job_done),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/sle_front.sv =====
module sle_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_wr_data,
   input  logic            accept,
   input  sle_pkg::req_type item,
   output logic            job_push,
   output sle_pkg::job_type job
);
   import sle_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic       held_ff, held_in;
   logic       full_set;
   logic       keeps;
   logic       hold;
   logic [7:0] span_off;
   logic [7:0] b;

   assign b        = item.in_byte;
   assign full_set = (mode_ff == MODE_LOOKAHEAD) || (mode_ff == MODE_FULL);
   assign span_off = b - CHAR_BSLASH;

   always_comb begin
      keeps = (b == CHAR_QUOTE) || (b == CHAR_DQUOTE);
      if ((b >= CHAR_BSLASH) && (span_off <= LOOKAHEAD_SPAN)) begin
         keeps = LOOKAHEAD_MASK[span_off[4:0]];
      end
   end

   always_comb begin
      job.last  = item.end_of_string;
      job.pre   = held_ff ? (keeps ? PRE_SINGLE : PRE_HEX) : PRE_NONE;
      job.body  = BODY_RAW;
      job.arg_a = b;
      job.arg_b = b;
      hold      = 1'b0;
      case (b)
         CHAR_AMP: begin
            job.body = BODY_HEX; job.arg_a = CHAR_2; job.arg_b = CHAR_6;
         end
         CHAR_LT: begin
            job.body = BODY_HEX; job.arg_a = CHAR_3; job.arg_b = CHAR_C;
         end
         CHAR_EQ: begin
            job.body = BODY_HEX; job.arg_a = CHAR_3; job.arg_b = CHAR_D;
         end
         CHAR_GT: begin
            job.body = BODY_HEX; job.arg_a = CHAR_3; job.arg_b = CHAR_E;
         end
         CHAR_QUOTE: begin
            if (full_set) begin
               job.body = BODY_HEX; job.arg_a = CHAR_2; job.arg_b = CHAR_7;
            end
         end
         CHAR_DQUOTE: begin
            if (full_set) begin
               job.body = BODY_HEX; job.arg_a = CHAR_2; job.arg_b = CHAR_2;
            end
         end
         CHAR_LF: begin
            if (full_set) begin
               job.body = BODY_PAIR; job.arg_a = CHAR_N;
            end
         end
         CHAR_CR: begin
            if (full_set) begin
               job.body = BODY_PAIR; job.arg_a = CHAR_R;
            end
         end
         CHAR_BSLASH: begin
            if (mode_ff == MODE_FULL) begin
               job.body = BODY_PAIR; job.arg_a = CHAR_BSLASH;
            end else if (mode_ff == MODE_LOOKAHEAD) begin
               if (item.end_of_string) begin
                  job.body = BODY_HEX; job.arg_a = CHAR_5; job.arg_b = CHAR_C;
               end else begin
                  // hold until the next byte decides
                  job.body = BODY_NONE;
                  hold     = 1'b1;
               end
            end
         end
         default: begin
            job.body = BODY_RAW;
         end
      endcase
   end

   // drop items that only store a backslash
   assign job_push = accept && ((job.pre != PRE_NONE) || (job.body != BODY_NONE));

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   assign held_in = accept ? hold : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LOOKAHEAD;
         held_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/sle_queue.sv =====
module sle_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  sle_pkg::job_type wr_job,
   output logic             q_full,
   input  logic             rd_en,
   output logic             rd_valid,
   output sle_pkg::job_type rd_job
);
   import sle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign q_full   = (count_ff == CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== rtl/sle_back.sv =====
module sle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sle_pkg::job_type job,
   output logic             job_done,
   input  logic             pop,
   output logic             empty,
   output sle_pkg::rsp_type rsp_item
);
   import sle_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic [2:0] pre_len;
   logic [2:0] body_len;
   logic [3:0] len;
   logic [2:0] j;
   logic [7:0] cur_byte;
   logic       at_end;
   logic       load;

   always_comb begin
      case (job.pre)
         PRE_SINGLE: pre_len = 3'd1;
         PRE_HEX:    pre_len = 3'd4;
         default:    pre_len = 3'd0;
      endcase
      case (job.body)
         BODY_RAW:  body_len = 3'd1;
         BODY_PAIR: body_len = 3'd2;
         BODY_HEX:  body_len = 3'd4;
         default:   body_len = 3'd0;
      endcase
   end

   assign len    = {1'b0, pre_len} + {1'b0, body_len};
   assign at_end = ({1'b0, idx_ff} == (len - 4'd1));
   assign j      = idx_ff - pre_len;

   always_comb begin
      if (idx_ff < pre_len) begin
         if (job.pre == PRE_SINGLE) begin
            cur_byte = CHAR_BSLASH;
         end else begin
            case (idx_ff[1:0])
               2'd0:    cur_byte = CHAR_BSLASH;
               2'd1:    cur_byte = CHAR_X;
               2'd2:    cur_byte = CHAR_5;
               default: cur_byte = CHAR_C;
            endcase
         end
      end else begin
         case (job.body)
            BODY_PAIR: cur_byte = (j == 3'd0) ? CHAR_BSLASH : job.arg_a;
            BODY_HEX: begin
               case (j[1:0])
                  2'd0:    cur_byte = CHAR_BSLASH;
                  2'd1:    cur_byte = CHAR_X;
                  2'd2:    cur_byte = job.arg_a;
                  default: cur_byte = job.arg_b;
               endcase
            end
            default: cur_byte = job.arg_a;
         endcase
      end
   end

   // advance one beat whenever the output stage is free or being drained
   assign load     = job_valid && (!out_valid_ff || pop);
   assign job_done = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      if (load) begin
         idx_in              = at_end ? 3'd0 : idx_ff + 3'd1;
         out_in.out_byte     = cur_byte;
         out_in.last_of_run  = at_end;
         out_in.string_done  = at_end && job.last;
         out_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import sle_pkg::*;

   localparam logic [1:0] MODE_MARKUP_ALIAS = 2'd3;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_Q = 8'h71;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PRINT_CAP = 40;
   localparam int PHASE_ITEMS = 48;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   req_type    req_item = '0;
   logic       empty;
   logic       pop = 1'b0;
   rsp_type    rsp_item;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = '0;

   req_type    raw_bytes_due[$];
   rsp_type    escaped_due[$];
   logic [7:0] run_buf[$];
   logic [1:0] mode_copy = MODE_LOOKAHEAD;
   logic       held_copy = 1'b0;
   int         idle_pct = 6;
   int         err_count = 0;
   int         cycle_count = 0;

   logic [1:0] phase_modes [0:7] = '{MODE_FULL, MODE_MARKUP, MODE_MARKUP_ALIAS,
                                     MODE_LOOKAHEAD, MODE_FULL, MODE_LOOKAHEAD,
                                     MODE_MARKUP, MODE_LOOKAHEAD};

   string_literal_escaper_top uut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_item    (req_item),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      if (err_count < PRINT_CAP)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   task automatic add_byte(logic [7:0] v);
      run_buf = {run_buf, v};
   endtask

   task automatic add_hex(logic [7:0] hi, logic [7:0] lo);
      add_byte(CHAR_BSLASH);
      add_byte(CHAR_X);
      add_byte(hi);
      add_byte(lo);
   endtask

   function automatic bit stays_single(logic [7:0] b);
      return b == CHAR_BSLASH || b == CHAR_N || b == CHAR_R || b == CHAR_T ||
             b == CHAR_QUOTE || b == CHAR_DQUOTE;
   endfunction

   // Expected output beats for one accepted input byte.
   task automatic predict_escape(req_type r);
      logic [7:0] b;
      bit         full_set;
      rsp_type    e;
      b = r.in_byte;
      full_set = (mode_copy == MODE_LOOKAHEAD || mode_copy == MODE_FULL);
      run_buf.delete();
      // resolve a pending backslash before the byte itself
      if (held_copy) begin
         if (stays_single(b))
            add_byte(CHAR_BSLASH);
         else
            add_hex(CHAR_5, CHAR_C);
         held_copy = 1'b0;
      end
      case (b)
         CHAR_AMP: add_hex(CHAR_2, CHAR_6);
         CHAR_LT:  add_hex(CHAR_3, CHAR_C);
         CHAR_EQ:  add_hex(CHAR_3, CHAR_D);
         CHAR_GT:  add_hex(CHAR_3, CHAR_E);
         CHAR_QUOTE: begin
            if (full_set) add_hex(CHAR_2, CHAR_7);
            else add_byte(b);
         end
         CHAR_DQUOTE: begin
            if (full_set) add_hex(CHAR_2, CHAR_2);
            else add_byte(b);
         end
         CHAR_LF: begin
            if (full_set) begin
               add_byte(CHAR_BSLASH);
               add_byte(CHAR_N);
            end else begin
               add_byte(b);
            end
         end
         CHAR_CR: begin
            if (full_set) begin
               add_byte(CHAR_BSLASH);
               add_byte(CHAR_R);
            end else begin
               add_byte(b);
            end
         end
         CHAR_BSLASH: begin
            if (!full_set) begin
               add_byte(b);
            end else if (mode_copy == MODE_FULL) begin
               add_byte(CHAR_BSLASH);
               add_byte(CHAR_BSLASH);
            end else if (r.end_of_string) begin
               add_hex(CHAR_5, CHAR_C);
            end else begin
               held_copy = 1'b1;
            end
         end
         default: add_byte(b);
      endcase
      for (int k = 0; k < run_buf.size(); k++) begin
         e.out_byte = run_buf[k];
         e.last_of_run = (k == run_buf.size() - 1);
         e.string_done = e.last_of_run && r.end_of_string;
         escaped_due = {escaped_due, e};
      end
   endtask

   // input side: present queued bytes, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (push)
            predict_escape(req_item);
         if (raw_bytes_due.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_item <= raw_bytes_due.pop_front();
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // output side: check each beat against the oldest expectation
   always @(posedge clock) begin : beat_monitor
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (escaped_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat byte=%02h", rsp_item.out_byte));
            end else begin
               want = escaped_due.pop_front();
               if (rsp_item.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_item.out_byte, want.out_byte));
               if (rsp_item.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, want %b",
                                            rsp_item.last_of_run, want.last_of_run));
               if (rsp_item.string_done !== want.string_done)
                  report_mismatch($sformatf("string_done %b, want %b",
                                            rsp_item.string_done, want.string_done));
            end
         end
         pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send(logic [7:0] b, logic eos);
      req_type r;
      r.in_byte = b;
      r.end_of_string = eos;
      raw_bytes_due = {raw_bytes_due, r};
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_copy = m;
      @(negedge clock);
   endtask

   // wait for all bytes accepted and all beats seen, then let a held byte settle
   task automatic drain();
      @(negedge clock);
      while (raw_bytes_due.size() != 0 || push || escaped_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // favor the bytes that the escaper treats specially
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if ($urandom_range(99) >= 45)
         return b;
      case ($urandom_range(13))
         0, 1: return CHAR_BSLASH;
         2:    return CHAR_N;
         3:    return CHAR_R;
         4:    return CHAR_T;
         5:    return CHAR_QUOTE;
         6:    return CHAR_DQUOTE;
         7:    return CHAR_AMP;
         8:    return CHAR_LT;
         9:    return CHAR_EQ;
         10:   return CHAR_GT;
         11:   return CHAR_LF;
         12:   return CHAR_CR;
         default: return CHAR_X;
      endcase
   endfunction

   initial begin
      int n;
      int len;
      bit noisy;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(MODE_LOOKAHEAD);

      send(8'h00, 1'b0);
      send(8'hff, 1'b0);
      send(CHAR_AMP, 1'b0);
      send(CHAR_LT, 1'b0);
      send(CHAR_EQ, 1'b0);
      send(CHAR_GT, 1'b0);
      send(CHAR_QUOTE, 1'b0);
      send(CHAR_DQUOTE, 1'b0);
      send(CHAR_LF, 1'b0);
      send(CHAR_CR, 1'b1);
      // backslash kept single before n, before another backslash
      send(CHAR_BSLASH, 1'b0);
      send(CHAR_N, 1'b0);
      send(CHAR_BSLASH, 1'b0);
      send(CHAR_BSLASH, 1'b0);
      send(CHAR_Q, 1'b0);
      // hex resolution followed by a hex escape: longest run
      send(CHAR_BSLASH, 1'b0);
      send(CHAR_AMP, 1'b0);
      send(CHAR_BSLASH, 1'b0);
      send(CHAR_DQUOTE, 1'b1);
      // backslash closing a string is not held
      send(CHAR_BSLASH, 1'b1);
      send(CHAR_BSLASH, 1'b0);
      drain();
      // held backslash survives a mode change
      write_mode(MODE_FULL);
      send(CHAR_A, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_mode(phase_modes[p]);
         idle_pct = (p == 4) ? 0 : 6;
         n = 0;
         while (n < PHASE_ITEMS) begin
            len = $urandom_range(1, 10);
            noisy = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++) begin
               if (noisy)
                  send(pick_byte(), 1'($urandom_range(1)));
               else
                  send(pick_byte(), i == len - 1);
            end
            n += len;
         end
         drain();
      end

      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
